### rtl/lrt_pkg.sv
// Shared types and constants of the lap and run timer.
`default_nettype none
package lrt_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned IDX_W  = 4;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_OPERATION_MODE = 1'b0;
  localparam logic REG_SENSOR_MODE    = 1'b1;

  // Field codes
  localparam logic OP_LAP      = 1'b0;
  localparam logic OP_RUN      = 1'b1;
  localparam logic SENS_SINGLE = 1'b0;
  localparam logic SENS_DUAL   = 1'b1;
  localparam logic ACT_GATE    = 1'b0;
  localparam logic ACT_STOP    = 1'b1;

  // Command queue between classifier and executor
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LAP,
    CMD_RUN,
    CMD_DSTART,
    CMD_DSTOP
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t         code;
    logic [TIME_W-1:0] t;
  } cmd_t;

  typedef struct packed {
    logic operation_mode;
    logic sensor_mode;
  } cfg_t;

endpackage
`default_nettype wire

### rtl/lrt_if.sv
// Channel interfaces: gate crossings in, lap results out.
`default_nettype none
interface lrt_gate_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] event_ms;

  modport source (output valid, output action, output event_ms, input ready);
  modport sink   (input valid, input action, input event_ms, output ready);
endinterface

interface lrt_res_if;
  logic        valid;
  logic        ready;
  logic        lap_done;
  logic [3:0]  done_index;
  logic [31:0] done_start_ms;
  logic [31:0] done_end_ms;
  logic        run_started;

  modport source (output valid, output lap_done, output done_index, output done_start_ms,
                  output done_end_ms, output run_started, input ready);
  modport sink   (input valid, input lap_done, input done_index, input done_start_ms,
                  input done_end_ms, input run_started, output ready);
endinterface
`default_nettype wire

### rtl/lrt_front.sv
// Front stage: accepts gate crossings and classifies them into commands.
`default_nettype none
module lrt_front import lrt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  lrt_gate_if.sink    crossing,
  output logic        push_valid,
  input  wire logic   push_ready,
  output cmd_t        push_data
);

  logic      f_valid;
  cmd_t      f_cmd;
  cmd_code_t code;
  logic      take;

  assign crossing.ready = !f_valid || push_ready;
  assign take           = crossing.valid && crossing.ready;
  assign push_valid     = f_valid;
  assign push_data      = f_cmd;

  always_comb begin
    if (cfg.operation_mode == OP_LAP) begin
      code = (cfg.sensor_mode == SENS_SINGLE && crossing.action == ACT_GATE) ? CMD_LAP
                                                                             : CMD_NONE;
    end else if (cfg.sensor_mode == SENS_SINGLE) begin
      code = (crossing.action == ACT_GATE) ? CMD_RUN : CMD_NONE;
    end else begin
      code = (crossing.action == ACT_GATE) ? CMD_DSTART : CMD_DSTOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (push_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_cmd.code <= code;
      f_cmd.t    <= crossing.event_ms;
    end
  end

endmodule
`default_nettype wire

### rtl/lrt_queue.sv
// Short command queue between the front and back stages.
`default_nettype none
module lrt_queue import lrt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_data
);

  cmd_t            entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = (count != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

### rtl/lrt_back.sv
// Back stage: executes commands against the lap ring and registers the result.
`default_nettype none
module lrt_back import lrt_pkg::*; #(
  parameter int unsigned MAX_LAPS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic pop_valid,
  output logic      pop_ready,
  input  wire cmd_t pop_data,
  lrt_res_if.source result
);

  localparam int unsigned SLOT_W = (MAX_LAPS > 1) ? $clog2(MAX_LAPS) : 1;

  // Only the current slot's start time is ever read, and it is written whenever
  // the slot moves, so one register holds it; end times matter only as set/unset.
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   slot_next;
  logic [SLOT_W-1:0]   slot_eff;
  logic [SLOT_W-1:0]   slot_inc;
  logic                active;
  logic                active_next;
  logic [TIME_W-1:0]   cur_start;
  logic [TIME_W-1:0]   start_next;
  logic [TIME_W-1:0]   start_eff;
  logic [MAX_LAPS-1:0] end_set;
  logic                end_zero;
  logic                end_wr;
  logic                end_val;
  logic                pop;

  logic                r_done;
  logic [IDX_W-1:0]    r_idx;
  logic [TIME_W-1:0]   r_start;
  logic [TIME_W-1:0]   r_end;
  logic                r_run;

  assign pop_ready = !result.valid || result.ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    slot_eff    = active ? slot : '0;
    start_eff   = active ? cur_start : '0;
    slot_inc    = (slot_eff == SLOT_W'(MAX_LAPS - 1)) ? '0 : slot_eff + 1'b1;
    end_zero    = !end_set[slot_eff];
    active_next = active;
    slot_next   = slot;
    start_next  = cur_start;
    end_wr      = 1'b0;
    end_val     = 1'b0;
    r_done      = 1'b0;
    r_idx       = '0;
    r_start     = '0;
    r_end       = '0;
    r_run       = 1'b0;

    unique case (pop_data.code)
      CMD_LAP: begin
        active_next = 1'b1;
        start_next  = pop_data.t;
        if (!active) begin
          slot_next = '0;
        end else begin
          r_done    = 1'b1;
          r_idx     = IDX_W'(slot_eff);
          r_start   = start_eff;
          r_end     = pop_data.t;
          end_wr    = 1'b1;
          end_val   = (pop_data.t != '0);
          slot_next = slot_inc;
        end
      end
      CMD_RUN: begin
        if (!active) begin
          active_next = 1'b1;
          slot_next   = '0;
          start_next  = pop_data.t;
          end_wr      = 1'b1;
        end else if (end_zero && cur_start != '0) begin
          r_done     = 1'b1;
          r_idx      = IDX_W'(slot_eff);
          r_start    = start_eff;
          r_end      = pop_data.t;
          end_wr     = 1'b1;
          end_val    = (pop_data.t != '0);
          slot_next  = slot_inc;
          start_next = '0;
        end else if (cur_start == '0) begin
          start_next = pop_data.t;
          end_wr     = 1'b1;
          r_run      = 1'b1;
        end
      end
      CMD_DSTART: begin
        // first event of either gate opens slot zero with its start cleared
        active_next = 1'b1;
        slot_next   = slot_eff;
        start_next  = start_eff;
        if (start_eff == '0) begin
          start_next = pop_data.t;
          end_wr     = 1'b1;
          r_run      = 1'b1;
        end
      end
      CMD_DSTOP: begin
        active_next = 1'b1;
        slot_next   = slot_eff;
        start_next  = start_eff;
        if (end_zero && start_eff != '0) begin
          r_done     = 1'b1;
          r_idx      = IDX_W'(slot_eff);
          r_start    = start_eff;
          r_end      = pop_data.t;
          end_wr     = 1'b1;
          end_val    = (pop_data.t != '0);
          slot_next  = slot_inc;
          start_next = '0;
        end
      end
      CMD_NONE: begin
        active_next = active;
      end
      default: begin
        active_next = active;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      slot         <= '0;
      cur_start    <= '0;
      end_set      <= '0;
      result.valid <= 1'b0;
    end else begin
      if (pop) begin
        active    <= active_next;
        slot      <= slot_next;
        cur_start <= start_next;
        if (end_wr) begin
          end_set[slot_eff] <= end_val;
        end
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.lap_done      <= r_done;
      result.done_index    <= r_idx;
      result.done_start_ms <= r_start;
      result.done_end_ms   <= r_end;
      result.run_started   <= r_run;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.lap_done && result.run_started))
    else $error("lap close and run start reported together");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= SLOT_W'(MAX_LAPS - 1))
    else $error("current slot beyond ring");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.lap_done) |->
      (result.done_index == '0 && result.done_start_ms == '0 && result.done_end_ms == '0))
    else $error("lap fields set without a closed lap");

  a_inactive_no_close: assert property (@(posedge clk) disable iff (rst)
    (pop && !active) |=> !result.lap_done)
    else $error("lap closed before timing was active");

endmodule
`default_nettype wire

### rtl/lap_run_timer.sv
// Top level of the gate-driven lap and run timer.
// Takes one gate crossing per clock unless back-pressure stalls it, and returns
// exactly one result per crossing, in order; each crossing passes through the
// front register, the command queue and the result register. The sustained rate
// is one item per cycle when nothing stalls, set by the read-modify-write of the
// current lap slot in the back stage. A two-entry command queue sits between the
// classifying front stage and the back stage, so either side may stall without
// blocking the other. The lap ring is held in flip-flops and cleared by reset;
// no clearing pass is needed. Registers: operation_mode at byte address 0,
// sensor_mode at byte address 4; write them only while the block is idle.
`default_nettype none
module lap_run_timer import lrt_pkg::*; #(
  parameter int unsigned MAX_LAPS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  lrt_gate_if.sink               crossing,
  lrt_res_if.source              result
);

  cfg_t cfg;
  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SENSOR_MODE) ? APB_DW'(cfg.sensor_mode)
                                                : APB_DW'(cfg.operation_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_OPERATION_MODE: cfg.operation_mode <= pwdata[0];
        REG_SENSOR_MODE:    cfg.sensor_mode    <= pwdata[0];
        default:            cfg                <= cfg;
      endcase
    end
  end

  lrt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .crossing   (crossing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lrt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lrt_back #(
    .MAX_LAPS (MAX_LAPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule
`default_nettype wire

### tb/sv/tb_lap_run_timer.sv
// Self-checking testbench of the lap and run timer: random gate crossings, lap result checks.
`timescale 1ns / 100ps
module tb_lap_run_timer;
  import lrt_pkg::*;

  localparam int LAPS = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Random phases: operation and sensor mode per phase, bit p for phase p
  localparam int N_PHASES = 7;
  localparam logic [N_PHASES-1:0] PH_OP   = 7'b1100110;
  localparam logic [N_PHASES-1:0] PH_SENS = 7'b0101100;

  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] ms;
  } gate_item_t;

  typedef struct packed {
    logic              lap_done;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] start_ms;
    logic [TIME_W-1:0] end_ms;
    logic              run_started;
  } lap_report_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lrt_gate_if crossing_if ();
  lrt_res_if  result_if ();

  lap_run_timer #(.MAX_LAPS(LAPS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .crossing (crossing_if),
    .result   (result_if)
  );

  // Predicted timer state and register copies
  logic [TIME_W-1:0] lap_start_ms [LAPS];
  logic [TIME_W-1:0] lap_end_ms [LAPS];
  logic [IDX_W-1:0]  open_slot;
  logic              timing_on;
  logic              cfg_op;
  logic              cfg_sens;

  gate_item_t  crossing_q [$];
  lap_report_t lap_reports_q [$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned recv_count = 0;
  int          gate_gap = 0;
  int          res_stall = 0;
  bit          gate_no_idle = 1'b0;
  bit          res_no_idle = 1'b0;

  always #2 clk = ~clk;

  function automatic void close_lap(input logic [TIME_W-1:0] t, inout lap_report_t r);
    lap_end_ms[open_slot] = t;
    r.lap_done = 1'b1;
    r.idx = open_slot;
    r.start_ms = lap_start_ms[open_slot];
    r.end_ms = t;
    open_slot = (open_slot == LAPS - 1) ? '0 : open_slot + 1'b1;
  endfunction

  // Advance the predicted timer by one crossing and return its report
  function automatic lap_report_t time_crossing(input logic act, input logic [TIME_W-1:0] t);
    lap_report_t r;
    r = '0;
    if (cfg_op == OP_LAP) begin
      if (cfg_sens == SENS_SINGLE && act == ACT_GATE) begin
        if (!timing_on) begin
          timing_on = 1'b1;
          open_slot = '0;
        end else begin
          close_lap(t, r);
        end
        lap_start_ms[open_slot] = t;
      end
    end else if (cfg_sens == SENS_SINGLE) begin
      if (act == ACT_GATE) begin
        if (!timing_on) begin
          timing_on = 1'b1;
          open_slot = '0;
          lap_start_ms[0] = t;
          lap_end_ms[0] = '0;
        end else if (lap_end_ms[open_slot] == 0 && lap_start_ms[open_slot] != 0) begin
          close_lap(t, r);
          lap_start_ms[open_slot] = '0;
        end else if (lap_start_ms[open_slot] == 0) begin
          lap_start_ms[open_slot] = t;
          lap_end_ms[open_slot] = '0;
          r.run_started = 1'b1;
        end
      end
    end else begin
      if (!timing_on) begin
        timing_on = 1'b1;
        open_slot = '0;
        lap_start_ms[0] = '0;
      end
      if (act == ACT_GATE) begin
        if (lap_start_ms[open_slot] == 0) begin
          lap_start_ms[open_slot] = t;
          lap_end_ms[open_slot] = '0;
          r.run_started = 1'b1;
        end
      end else if (lap_end_ms[open_slot] == 0 && lap_start_ms[open_slot] != 0) begin
        close_lap(t, r);
        lap_start_ms[open_slot] = '0;
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic logic [TIME_W-1:0] pick_time(input bit allow_zero);
    logic [TIME_W-1:0] t;
    case ($urandom_range(0, 11))
      0: t = allow_zero ? '0 : 32'd1;
      1: t = 32'hFFFF_FFFF;
      2: t = $urandom_range(1, 255);
      default: t = $urandom;
    endcase
    if (t == 0 && !allow_zero) t = 32'd1;
    return t;
  endfunction

  task automatic push_crossing(input logic act, input logic [TIME_W-1:0] t);
    gate_item_t item;
    item.action = act;
    item.ms = t;
    crossing_q.push_back(item);
  endtask

  // Hold until every queued crossing is transferred and every report checked
  task automatic drain();
    do @(negedge clk);
    while (crossing_q.size() != 0 || crossing_if.valid || lap_reports_q.size() != 0);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_modes(input logic op, input logic sens);
    drain();
    repeat (4) @(posedge clk);
    write_reg({REG_OPERATION_MODE, 2'b00}, {{(APB_DW-1){1'b0}}, op});
    cfg_op = op;
    write_reg({REG_SENSOR_MODE, 2'b00}, {{(APB_DW-1){1'b0}}, sens});
    cfg_sens = sens;
  endtask

  // Mostly well-formed crossings for the current mode, the rest noise
  task automatic gen_phase(input int unsigned n);
    int unsigned k;
    logic        act;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 4) != 0) begin
        push_crossing(ACT_GATE, pick_time(1'b0));
        k++;
        if (cfg_sens == SENS_DUAL) begin
          push_crossing(ACT_STOP, pick_time(1'b0));
          k++;
        end
      end else begin
        act = logic'($urandom_range(0, 1));
        push_crossing(act, pick_time(1'b1));
        // stop gate in single-gate modes is dropped by the block
        if (!(cfg_sens == SENS_SINGLE && act == ACT_STOP)) k++;
      end
    end
  endtask

  // Crossing driver
  always @(posedge clk) begin : p_driver
    gate_item_t item;
    if (rst) begin
      crossing_if.valid <= 1'b0;
      gate_gap = 0;
    end else begin
      if (crossing_if.valid && crossing_if.ready) begin
        lap_reports_q.push_back(time_crossing(crossing_if.action, crossing_if.event_ms));
      end
      if (!crossing_if.valid || crossing_if.ready) begin
        if (gate_gap > 0) begin
          gate_gap--;
          crossing_if.valid <= 1'b0;
        end else if (crossing_q.size() != 0) begin
          item = crossing_q.pop_front();
          crossing_if.valid    <= 1'b1;
          crossing_if.action   <= item.action;
          crossing_if.event_ms <= item.ms;
          sent_count++;
          if (sent_count % 48 == 0) gate_no_idle = ($urandom_range(0, 3) == 0);
          gate_gap = gate_no_idle ? 0 : $urandom_range(0, 17);
        end else begin
          crossing_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : p_monitor
    lap_report_t want;
    if (rst) begin
      result_if.ready <= 1'b0;
      res_stall = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (lap_reports_q.size() == 0) begin
          $error("result transfer with no crossing outstanding");
          fail_count++;
        end else begin
          want = lap_reports_q.pop_front();
          check_field("lap_done", 32'(want.lap_done), 32'(result_if.lap_done));
          check_field("done_index", 32'(want.idx), 32'(result_if.done_index));
          check_field("done_start_ms", want.start_ms, result_if.done_start_ms);
          check_field("done_end_ms", want.end_ms, result_if.done_end_ms);
          check_field("run_started", 32'(want.run_started), 32'(result_if.run_started));
        end
        recv_count++;
        if (recv_count % 48 == 0) res_no_idle = ($urandom_range(0, 3) == 0);
        res_stall = res_no_idle ? 0 : $urandom_range(0, 17);
      end
      if (res_stall > 0) begin
        res_stall--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL lap_run_timer");
      $finish;
    end
  end

  initial begin : p_stimulus
    int unsigned first_mode;
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    crossing_if.valid = 1'b0;
    crossing_if.action = ACT_GATE;
    crossing_if.event_ms = '0;
    result_if.ready = 1'b0;
    for (int i = 0; i < LAPS; i++) begin
      lap_start_ms[i] = '0;
      lap_end_ms[i] = '0;
    end
    open_slot = '0;
    timing_on = 1'b0;
    cfg_op = OP_LAP;
    cfg_sens = SENS_SINGLE;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // First crossing after reset lands in a random mode: lap, single run or dual gates
    first_mode = $urandom_range(0, 2);
    set_modes(first_mode != 0 ? OP_RUN : OP_LAP, first_mode == 2 ? SENS_DUAL : SENS_SINGLE);
    push_crossing(first_mode == 2 ? logic'($urandom_range(0, 1)) : ACT_GATE, 32'd100);
    push_crossing(ACT_GATE, 32'hFFFF_FFFF);

    set_modes(OP_LAP, SENS_SINGLE);
    push_crossing(ACT_GATE, 32'h0000_0064);
    push_crossing(ACT_GATE, 32'hFFFF_FFFF);
    push_crossing(ACT_STOP, 32'h1234_5678);
    push_crossing(ACT_GATE, 32'd0);
    push_crossing(ACT_GATE, 32'd1);

    // single run: start, close, zero start, restart, stray stop, close, start
    set_modes(OP_RUN, SENS_SINGLE);
    push_crossing(ACT_GATE, 32'd500);
    push_crossing(ACT_GATE, 32'd900);
    push_crossing(ACT_GATE, 32'd0);
    push_crossing(ACT_GATE, 32'd7);
    push_crossing(ACT_STOP, 32'd5);
    push_crossing(ACT_GATE, 32'd20);
    push_crossing(ACT_GATE, 32'd20);

    set_modes(OP_RUN, SENS_DUAL);
    push_crossing(ACT_STOP, 32'd30);
    push_crossing(ACT_GATE, 32'd40);
    push_crossing(ACT_GATE, 32'd50);
    push_crossing(ACT_STOP, 32'hFFFF_FFFF);
    push_crossing(ACT_STOP, 32'd60);
    push_crossing(ACT_GATE, 32'd0);
    push_crossing(ACT_STOP, 32'd9);

    // lap mode with two gates drops everything
    set_modes(OP_LAP, SENS_DUAL);
    push_crossing(ACT_GATE, 32'd1);
    push_crossing(ACT_STOP, 32'd2);

    for (int p = 0; p < N_PHASES; p++) begin
      set_modes(PH_OP[p], PH_SENS[p]);
      if (PH_OP[p] == OP_LAP && PH_SENS[p] == SENS_DUAL) begin
        repeat (20) push_crossing(logic'($urandom_range(0, 1)), pick_time(1'b1));
      end else begin
        gen_phase(95);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS lap_run_timer");
    end else begin
      $display("FAIL lap_run_timer");
    end
    $finish;
  end

endmodule
